// File: design/dmbrf_pkg.sv
// ----------------------------------------------------------------------------
// dmbrf_pkg
// Shared types and constants for the depth map bleed reject and fill block.
// ----------------------------------------------------------------------------
package dmbrf_pkg;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 256;

  // signed working width for pixel coordinates with window offsets
  localparam int CSW = 16;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_RUN  = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;
  localparam logic [1:0] ACT_NOP  = 2'd3;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WRAP   = 2'd2;

  localparam logic [63:0] BLEED_SLACK_X20 = 64'd13100;  // 20 * 655
  localparam logic [3:0]  FILL_MIN_COUNT  = 4'd4;
  localparam logic [1:0]  FILL_LAST_PASS  = 2'd3;       // four passes

  typedef struct packed {
    logic [1:0]  action;
    logic [8:0]  column;
    logic [7:0]  row;
    logic [31:0] depth_in;
  } cmd_t;

  typedef struct packed {
    logic [31:0] depth_out;
    logic        read_valid;
  } result_t;

endpackage

// File: design/depth_map_bleed_reject_and_fill.sv
// ----------------------------------------------------------------------------
// depth_map_bleed_reject_and_fill
// Depth frame store with windowed-minimum bleed rejection and hole filling.
// ----------------------------------------------------------------------------
// Every accepted command gives exactly one result beat on done, which the
// receiver must take in that cycle. A load, a no-op or a read outside the frame
// is answered straight from idle; a read inside the frame first passes the read
// state for the registered memory read. A run walks the frame in turn with
// a row-minimum and a column-minimum pass each of W*H*(2r+1) reads, a
// rejection pass of W*H reads, then four fill passes, each with W*H center
// reads, up to 8 neighbor reads per empty pixel, a serial divide per filled
// pixel and a W*H copy-back.
// busy is high while a read inside the frame or a run is in flight; a load, a
// no-op or a read outside the frame never raises it.
module depth_map_bleed_reject_and_fill #(
  parameter int MAX_WIDTH  = dmbrf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = dmbrf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  dmbrf_pkg::cmd_t     cmd,
  output logic                done,
  output dmbrf_pkg::result_t  result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int CSW   = dmbrf_pkg::CSW;
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int WORDS = MAX_WIDTH * MAX_HEIGHT;
  localparam int BIG   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int KMAX  = ((BIG + 400) / 800 < 1) ? 1 : (BIG + 400) / 800;
  localparam int KW    = $clog2(KMAX + 1) + 2;
  localparam int W_RST = (512 > MAX_WIDTH) ? MAX_WIDTH : 512;
  localparam int H_RST = (256 > MAX_HEIGHT) ? MAX_HEIGHT : 256;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_ROW_RD, S_ROW_ACC, S_COL_RD, S_COL_ACC, S_REJ_RD, S_REJ_CHK,
    S_FC_RD, S_FC_CHK, S_FN_RD, S_FN_ACC, S_F_EVAL, S_F_DIV, S_COPY_RD, S_COPY_WR
  } state_t;

  state_t state;

  logic [9:0] frame_width;
  logic [8:0] frame_height;
  logic       wrap_columns;

  logic [XW-1:0]        x;
  logic [YW-1:0]        y;
  logic signed [KW-1:0] k;
  logic signed [KW-1:0] rad;
  logic signed [1:0]    dy, dx;
  logic [1:0]           pass;
  logic [31:0]          m;
  logic [31:0]          lo, hi;
  logic [34:0]          sum;
  logic [3:0]           n;
  logic [34:0]          quo;
  logic [3:0]           rem;
  logic [5:0]           dcnt;

  logic [31:0] mem_a [WORDS];
  logic [31:0] mem_b [WORDS];
  logic [31:0] mem_c [WORDS];
  logic [31:0] a_rdata, b_rdata, c_rdata;
  logic [AW-1:0] a_raddr, a_waddr, b_raddr, c_raddr, pix_addr;
  logic a_we, b_we, c_we;
  logic [31:0] a_wdata, b_wdata;

  logic signed [CSW-1:0] w_s, h_s, xs, ys;
  logic accept, in_frame, last_x, last_pix, last_nb, row_skip, rej, spread_ok;
  logic done_next;
  logic signed [KW-1:0] rad_calc;
  logic [31:0] m_src, m_new;
  logic signed [CSW-1:0] ny;
  logic [4:0] div_t;

  function automatic logic [AW-1:0] addr_of(input logic signed [CSW-1:0] r,
                                            input logic signed [CSW-1:0] c);
    addr_of = AW'(r) * AW'(MAX_WIDTH) + AW'(c);
  endfunction

  function automatic logic signed [CSW-1:0] map_col(input logic signed [CSW-1:0] v,
                                                    input logic signed [CSW-1:0] w,
                                                    input logic wr);
    logic signed [CSW-1:0] t;
    t = v;
    if (wr) begin
      for (int i = 0; i < KMAX; i++) if (t < 0) t = t + w;
      for (int i = 0; i < KMAX; i++) if (t >= w) t = t - w;
    end else begin
      if (t < 0) t = '0;
      if (t >= w) t = w - CSW'(1);
    end
    map_col = t;
  endfunction

  function automatic logic [31:0] nz_min(input logic [31:0] a, input logic [31:0] v);
    nz_min = (v != '0 && (a == '0 || v < a)) ? v : a;
  endfunction

  function automatic logic [9:0] sat_w(input logic [9:0] v);
    logic [31:0] e;
    e = 32'(v);
    if (e < 32'd3) sat_w = 10'd3;
    else if (e > 32'(MAX_WIDTH)) sat_w = 10'(MAX_WIDTH);
    else sat_w = v;
  endfunction

  function automatic logic [8:0] sat_h(input logic [8:0] v);
    logic [31:0] e;
    e = 32'(v);
    if (e < 32'd3) sat_h = 9'd3;
    else if (e > 32'(MAX_HEIGHT)) sat_h = 9'(MAX_HEIGHT);
    else sat_h = v;
  endfunction

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[3:2])
      dmbrf_pkg::REG_WIDTH:  prdata = 32'(frame_width);
      dmbrf_pkg::REG_HEIGHT: prdata = 32'(frame_height);
      dmbrf_pkg::REG_WRAP:   prdata = 32'(wrap_columns);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 10'(W_RST);
      frame_height <= 9'(H_RST);
      wrap_columns <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        dmbrf_pkg::REG_WIDTH:  frame_width  <= sat_w(pwdata[9:0]);
        dmbrf_pkg::REG_HEIGHT: frame_height <= sat_h(pwdata[8:0]);
        dmbrf_pkg::REG_WRAP:   wrap_columns <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    logic [CSW-1:0] bigv;
    w_s  = signed'(CSW'(frame_width));
    h_s  = signed'(CSW'(frame_height));
    xs   = signed'(CSW'(x));
    ys   = signed'(CSW'(y));
    bigv = (frame_width > 10'(frame_height)) ? CSW'(frame_width) : CSW'(frame_height);
    rad_calc = KW'(1);
    for (int i = 2; i <= KMAX; i++) begin
      if (32'(bigv) + 32'd400 >= 32'(800 * i)) rad_calc = KW'(i);
    end
    in_frame = (10'(cmd.column) < frame_width) && (9'(cmd.row) < frame_height);
    last_x   = (xs == w_s - CSW'(1));
    last_pix = last_x && (ys == h_s - CSW'(1));
    last_nb  = (dy == 2'sd1) && (dx == 2'sd1);
    ny       = ys + CSW'(dy);
    row_skip = (ny < 0) || (ny >= h_s) || (dy == 2'sd0 && dx == 2'sd0);
    pix_addr = addr_of(ys, xs);
    m_src    = (state == S_COL_ACC) ? b_rdata : a_rdata;
    m_new    = nz_min(m, m_src);
    rej      = (c_rdata != '0) &&
               (64'(a_rdata) * 64'd20 > 64'(c_rdata) * 64'd21 + dmbrf_pkg::BLEED_SLACK_X20);
    spread_ok = (n >= dmbrf_pkg::FILL_MIN_COUNT) && (64'(hi) * 64'd20 <= 64'(lo) * 64'd21);
    div_t    = {rem, quo[34]};

    // one-cycle result beat: immediate commands, reads and the end of a run
    done_next = (state == S_IDLE && accept && cmd.action != dmbrf_pkg::ACT_RUN &&
                 !(cmd.action == dmbrf_pkg::ACT_READ && in_frame)) ||
                (state == S_READ) ||
                (state == S_COPY_WR && last_pix && pass == dmbrf_pkg::FILL_LAST_PASS);

    a_raddr = pix_addr;
    unique case (state)
      S_IDLE:   a_raddr = addr_of(signed'(CSW'(cmd.row)), signed'(CSW'(cmd.column)));
      S_ROW_RD: a_raddr = addr_of(ys, map_col(xs + CSW'(k), w_s, wrap_columns));
      S_FN_RD:  a_raddr = addr_of(ny, map_col(xs + CSW'(dx), w_s, wrap_columns));
      default:  a_raddr = pix_addr;
    endcase
    a_we    = 1'b0;
    a_waddr = pix_addr;
    a_wdata = '0;
    if (state == S_IDLE) begin
      a_we    = accept && cmd.action == dmbrf_pkg::ACT_LOAD && in_frame;
      a_waddr = addr_of(signed'(CSW'(cmd.row)), signed'(CSW'(cmd.column)));
      a_wdata = cmd.depth_in;
    end else if (state == S_REJ_CHK) begin
      a_we = rej;
    end else if (state == S_COPY_WR) begin
      a_we    = 1'b1;
      a_wdata = b_rdata;
    end

    b_raddr = pix_addr;
    if (state == S_COL_RD) begin
      b_raddr = addr_of((ys + CSW'(k) < 0) ? CSW'(0) :
                        (ys + CSW'(k) >= h_s) ? h_s - CSW'(1) : ys + CSW'(k), xs);
    end
    b_we    = 1'b0;
    b_wdata = '0;
    unique case (state)
      S_ROW_ACC: begin
        b_we    = (k == rad);
        b_wdata = m_new;
      end
      S_FC_CHK: begin
        b_we    = (a_rdata != '0);
        b_wdata = a_rdata;
      end
      S_F_EVAL: b_we = !spread_ok;
      S_F_DIV: begin
        b_we    = (dcnt == '0);
        b_wdata = {quo[30:0], (div_t >= 5'(n))};
      end
      default: ;
    endcase

    c_raddr = pix_addr;
    c_we    = (state == S_COL_ACC) && (k == rad);
  end

  always_ff @(posedge clk) begin
    if (a_we) mem_a[a_waddr] <= a_wdata;
    a_rdata <= mem_a[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) mem_b[pix_addr] <= b_wdata;
    b_rdata <= mem_b[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (c_we) mem_c[pix_addr] <= m_new;
    c_rdata <= mem_c[c_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= done_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            result <= '0;
            x      <= '0;
            y      <= '0;
            m      <= '0;
            rad    <= rad_calc;
            k      <= -rad_calc;
            pass   <= '0;
            if (cmd.action == dmbrf_pkg::ACT_RUN) begin
              state <= S_ROW_RD;
            end else if (cmd.action == dmbrf_pkg::ACT_READ && in_frame) begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          result.depth_out  <= a_rdata;
          result.read_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_ROW_RD: state <= S_ROW_ACC;
        S_ROW_ACC: begin
          if (k == rad) begin
            m <= '0;
            k <= -rad;
            x <= last_x ? '0 : x + XW'(1);
            if (last_pix) begin
              y     <= '0;
              state <= S_COL_RD;
            end else begin
              if (last_x) y <= y + YW'(1);
              state <= S_ROW_RD;
            end
          end else begin
            m     <= m_new;
            k     <= k + KW'(1);
            state <= S_ROW_RD;
          end
        end
        S_COL_RD: state <= S_COL_ACC;
        S_COL_ACC: begin
          if (k == rad) begin
            m <= '0;
            k <= -rad;
            x <= last_x ? '0 : x + XW'(1);
            if (last_pix) begin
              y     <= '0;
              state <= S_REJ_RD;
            end else begin
              if (last_x) y <= y + YW'(1);
              state <= S_COL_RD;
            end
          end else begin
            m     <= m_new;
            k     <= k + KW'(1);
            state <= S_COL_RD;
          end
        end
        S_REJ_RD: state <= S_REJ_CHK;
        S_REJ_CHK: begin
          x <= last_x ? '0 : x + XW'(1);
          if (last_pix) begin
            y     <= '0;
            state <= S_FC_RD;
          end else begin
            if (last_x) y <= y + YW'(1);
            state <= S_REJ_RD;
          end
        end
        S_FC_RD: state <= S_FC_CHK;
        S_FC_CHK: begin
          n   <= '0;
          lo  <= '0;
          hi  <= '0;
          sum <= '0;
          dy  <= -2'sd1;
          dx  <= -2'sd1;
          if (a_rdata != '0) begin
            x <= last_x ? '0 : x + XW'(1);
            if (last_pix) begin
              y     <= '0;
              state <= S_COPY_RD;
            end else begin
              if (last_x) y <= y + YW'(1);
              state <= S_FC_RD;
            end
          end else begin
            state <= S_FN_RD;
          end
        end
        S_FN_RD: begin
          if (!row_skip) begin
            state <= S_FN_ACC;
          end else if (last_nb) begin
            state <= S_F_EVAL;
          end else begin
            dx <= (dx == 2'sd1) ? -2'sd1 : dx + 2'sd1;
            if (dx == 2'sd1) dy <= dy + 2'sd1;
          end
        end
        S_FN_ACC: begin
          if (a_rdata != '0) begin
            if (n == '0 || a_rdata < lo) lo <= a_rdata;
            if (a_rdata > hi) hi <= a_rdata;
            sum <= sum + 35'(a_rdata);
            n   <= n + 4'd1;
          end
          if (last_nb) begin
            state <= S_F_EVAL;
          end else begin
            state <= S_FN_RD;
            dx <= (dx == 2'sd1) ? -2'sd1 : dx + 2'sd1;
            if (dx == 2'sd1) dy <= dy + 2'sd1;
          end
        end
        S_F_EVAL: begin
          quo  <= sum;
          rem  <= '0;
          dcnt <= 6'd34;
          if (spread_ok) begin
            state <= S_F_DIV;
          end else begin
            x <= last_x ? '0 : x + XW'(1);
            if (last_pix) begin
              y     <= '0;
              state <= S_COPY_RD;
            end else begin
              if (last_x) y <= y + YW'(1);
              state <= S_FC_RD;
            end
          end
        end
        S_F_DIV: begin
          // restoring divide, one quotient bit per cycle
          quo  <= {quo[33:0], (div_t >= 5'(n))};
          rem  <= (div_t >= 5'(n)) ? 4'(div_t - 5'(n)) : div_t[3:0];
          dcnt <= dcnt - 6'd1;
          if (dcnt == '0) begin
            x <= last_x ? '0 : x + XW'(1);
            if (last_pix) begin
              y     <= '0;
              state <= S_COPY_RD;
            end else begin
              if (last_x) y <= y + YW'(1);
              state <= S_FC_RD;
            end
          end
        end
        S_COPY_RD: state <= S_COPY_WR;
        S_COPY_WR: begin
          x <= last_x ? '0 : x + XW'(1);
          if (last_pix) begin
            y    <= '0;
            pass <= pass + 2'd1;
            if (pass == dmbrf_pkg::FILL_LAST_PASS) begin
              state <= S_IDLE;
            end else begin
              state <= S_FC_RD;
            end
          end else begin
            if (last_x) y <= y + YW'(1);
            state <= S_COPY_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/dmbrf_checker.sv
// ----------------------------------------------------------------------------
// dmbrf_checker
// Port-level checks on command and result beats of the depth cleanup block.
// ----------------------------------------------------------------------------
module dmbrf_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input dmbrf_pkg::cmd_t    cmd,
  input logic               done,
  input dmbrf_pkg::result_t result,
  input logic               pready
);

  logic go;
  assign go = start && !busy && !rst;

  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    go && (cmd.action == dmbrf_pkg::ACT_LOAD || cmd.action == dmbrf_pkg::ACT_NOP)
    |=> done && !result.read_valid)
    else $error("load or no-op beat not answered next cycle");

  a_valid_only_on_done: assert property (@(posedge clk) disable iff (rst)
    done && result.read_valid |-> $past(busy))
    else $error("read answer without a read in flight");

  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while still busy");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    go && cmd.action == dmbrf_pkg::ACT_RUN |=> busy && !done)
    else $error("run command finished at once");

  a_ready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

endmodule

bind depth_map_bleed_reject_and_fill dmbrf_checker u_dmbrf_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
  .done(done), .result(result), .pready(pready)
);
